[hdl/bgi_pkg.sv]
// Package for the bilinear grid interpolation core.
// Holds field widths, request kinds, register indexes and the sequencer state type.
`timescale 1ns / 1ps
package bgi_pkg;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 8;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W  = 17;
  localparam int QUO_W   = 16;
  localparam int ALU_W   = 34;

  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
  localparam logic [FRAC_W-1:0] FRAC_ZERO = 17'h00000;

  localparam logic [KIND_W-1:0] KIND_LOAD_ROW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_COL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_GRID = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIRST,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_MID,
    ST_TEST_MID,
    ST_TEST_NEXT,
    ST_RD_LO,
    ST_RD_HI,
    ST_SPAN,
    ST_DIFF,
    ST_DIV,
    ST_STORE,
    ST_G00,
    ST_G10,
    ST_G01,
    ST_G11,
    ST_GLAST,
    ST_LSUB,
    ST_LMUL,
    ST_LADD,
    ST_DONE
  } bgi_state_e;

endpackage

[hdl/bgi_req_if.sv]
// Request and response channel interfaces of the bilinear grid interpolation core.
// Depends on bgi_pkg for field widths.
`timescale 1ns / 1ps
interface bgi_req_if;
  logic                          valid;
  logic                          ready;
  logic [bgi_pkg::KIND_W-1:0]    kind;
  logic [bgi_pkg::SLOT_W-1:0]    slot;
  logic signed [bgi_pkg::VAL_W-1:0] value_a;
  logic signed [bgi_pkg::VAL_W-1:0] value_b;

  modport source (output valid, kind, slot, value_a, value_b, input ready);
  modport sink   (input valid, kind, slot, value_a, value_b, output ready);
endinterface

interface bgi_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [bgi_pkg::VAL_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

[hdl/bilinear_grid_interpolation_core.sv]
// Bilinear interpolation over a loadable breakpoint table, one shared ALU under a sequencer.
// Load requests are written at accept. A query runs, per axis, a bisection through one read
// port and a 16-step serial division, then 4 grid reads and 3 lerps; the core takes no new
// request until the query is done, and a result still waiting in the output register holds the
// done step. Reset (rst_ni low, asynchronous) clears control state and sets both counts to 2.
// Depends on bgi_pkg and the interfaces in bgi_req_if.sv.
`timescale 1ns / 1ps
module bilinear_grid_interpolation_core #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bgi_pkg::CNT_W-1:0]        cfg_wdata_i,
  bgi_req_if.sink                          req_i,
  bgi_rsp_if.source                        rsp_o
);
  import bgi_pkg::*;

  // Stored width of table entries.
  localparam int SB   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int MAXN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IW   = $clog2(MAXN);
  localparam int NW   = IW + 1;
  localparam int RIW  = $clog2(MAX_ROWS);
  localparam int CIW  = $clog2(MAX_COLS);
  localparam int GSZ  = MAX_ROWS * MAX_COLS;
  localparam int GAW  = $clog2(GSZ);
  localparam int MW   = ALU_W + FRAC_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] row_count_q, col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CNT_W'(2);
      col_count_q <= CNT_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT: row_count_q <= cfg_wdata_i;
        CFG_COL_COUNT: col_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective counts: below 2 acts as 2, above the table depth acts as the depth.
  logic [NW-1:0] nr_eff, nc_eff, n_eff;

  always_comb begin
    if (row_count_q < CNT_W'(2))              nr_eff = NW'(2);
    else if (32'(row_count_q) > MAX_ROWS)     nr_eff = NW'(MAX_ROWS);
    else                                      nr_eff = NW'(row_count_q);
    if (col_count_q < CNT_W'(2))              nc_eff = NW'(2);
    else if (32'(col_count_q) > MAX_COLS)     nc_eff = NW'(MAX_COLS);
    else                                      nc_eff = NW'(col_count_q);
  end

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  bgi_state_e state_q, state_d;
  logic                     axis_q, axis_d;       // 0 row search, 1 column search
  logic signed [VAL_W-1:0]  a_q, a_d, b_q, b_d;
  logic signed [NW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0]            mid_q, mid_d, j_q, j_d, ri_q, ri_d, ci_q, ci_d;
  logic signed [VAL_W-1:0]  loval_q, loval_d;
  logic signed [ALU_W-1:0]  span_q, span_d, rem_q, rem_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic [3:0]               cnt_q, cnt_d;
  logic [FRAC_W-1:0]        frac_q, frac_d, t_q, t_d, u_q, u_d;
  logic signed [VAL_W-1:0]  f00_q, f00_d, f10_q, f10_d, f01_q, f01_d, f11_q, f11_d;
  logic signed [VAL_W-1:0]  top_q, top_d, bot_q, bot_d;
  logic signed [ALU_W-1:0]  diff_q, diff_d, prod_q, prod_d;
  logic [1:0]               lsel_q, lsel_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]  out_data_q, out_data_d;

  // Memory ports
  logic [IW-1:0]            rd_idx;
  logic                     g_dr, g_dc;
  logic [GAW-1:0]           g_addr;
  logic signed [SB-1:0]     row_mem [MAX_ROWS];
  logic signed [SB-1:0]     col_mem [MAX_COLS];
  logic signed [SB-1:0]     grid_mem [GSZ];
  logic signed [SB-1:0]     row_rd_q, col_rd_q, grid_rd_q;

  // Shared ALU
  logic signed [ALU_W-1:0]  alu_a, alu_b, alu_y;
  logic                     alu_sub;

  logic                     req_acc;
  logic signed [VAL_W-1:0]  coord, bp, grid_val;
  logic [NW:0]              msum;
  logic                     div_bit;
  logic signed [VAL_W-1:0]  lp, lq;
  logic [FRAC_W-1:0]        lw;
  logic signed [MW-1:0]     mul_full;

  assign req_acc  = req_i.valid && req_i.ready;
  assign coord    = axis_q ? b_q : a_q;
  assign bp       = axis_q ? VAL_W'(col_rd_q) : VAL_W'(row_rd_q);
  assign grid_val = VAL_W'(grid_rd_q);
  assign n_eff    = axis_q ? nc_eff : nr_eff;
  assign msum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign alu_y    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign mul_full = diff_q * $signed({1'b0, lw});
  assign g_addr   = GAW'((32'(ri_q) + 32'(g_dr)) * MAX_COLS + 32'(ci_q) + 32'(g_dc));

  // Lerp operand selection: two lerps along the row axis, then one along the column axis.
  always_comb begin
    case (lsel_q)
      2'd0:    begin lp = f00_q; lq = f10_q; lw = t_q; end
      2'd1:    begin lp = f01_q; lq = f11_q; lw = t_q; end
      default: begin lp = top_q; lq = bot_q; lw = u_q; end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table storage: load writes at accept, registered reads for the sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.kind == KIND_LOAD_ROW && 32'(req_i.slot) < MAX_ROWS)
      row_mem[RIW'(req_i.slot)] <= req_i.value_a[SB-1:0];
    row_rd_q <= row_mem[RIW'(rd_idx)];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.kind == KIND_LOAD_COL && 32'(req_i.slot) < MAX_COLS)
      col_mem[CIW'(req_i.slot)] <= req_i.value_a[SB-1:0];
    col_rd_q <= col_mem[CIW'(rd_idx)];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.kind == KIND_LOAD_GRID && 32'(req_i.slot) < GSZ)
      grid_mem[GAW'(req_i.slot)] <= req_i.value_a[SB-1:0];
    grid_rd_q <= grid_mem[g_addr];
  end

  // ---------------------------------------------------------------------------
  // State register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      lsel_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      lsel_q      <= lsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;  b_q <= b_d;
    lo_q <= lo_d;  hi_q <= hi_d;  mid_q <= mid_d;  j_q <= j_d;
    ri_q <= ri_d;  ci_q <= ci_d;
    loval_q <= loval_d;  span_q <= span_d;  rem_q <= rem_d;  quo_q <= quo_d;
    frac_q <= frac_d;  t_q <= t_d;  u_q <= u_d;
    f00_q <= f00_d;  f10_q <= f10_d;  f01_q <= f01_d;  f11_q <= f11_d;
    top_q <= top_d;  bot_q <= bot_d;  diff_q <= diff_d;  prod_q <= prod_d;
    out_data_q <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;  axis_d = axis_q;  a_d = a_q;  b_d = b_q;
    lo_d = lo_q;  hi_d = hi_q;  mid_d = mid_q;  j_d = j_q;  ri_d = ri_q;  ci_d = ci_q;
    loval_d = loval_q;  span_d = span_q;  rem_d = rem_q;  quo_d = quo_q;  cnt_d = cnt_q;
    frac_d = frac_q;  t_d = t_q;  u_d = u_q;
    f00_d = f00_q;  f10_d = f10_q;  f01_d = f01_q;  f11_d = f11_q;
    top_d = top_q;  bot_d = bot_q;  diff_d = diff_q;  prod_d = prod_q;  lsel_d = lsel_q;
    out_valid_d = out_valid_q;  out_data_d = out_data_q;
    rd_idx = '0;  g_dr = 1'b0;  g_dc = 1'b0;
    alu_a = ALU_W'(coord);  alu_b = ALU_W'(loval_q);  alu_sub = 1'b1;
    div_bit = 1'b0;
    req_i.ready = 1'b0;

    // Drop the result once the sink takes it.
    if (out_valid_q && rsp_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && req_i.kind == KIND_QUERY) begin
          a_d     = req_i.value_a;
          b_d     = req_i.value_b;
          axis_d  = 1'b0;
          state_d = ST_FIRST;
        end
      end
      // Bisection: test both ends first, then narrow [lo,hi] over the brackets.
      ST_FIRST: begin
        rd_idx  = '0;
        state_d = ST_CHK_FIRST;
      end
      ST_CHK_FIRST: begin
        if (coord <= bp) begin
          j_d     = '0;
          state_d = ST_RD_LO;
        end else begin
          rd_idx  = IW'(n_eff - NW'(1));
          state_d = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (coord >= bp) begin
          j_d     = IW'(n_eff - NW'(2));
          state_d = ST_RD_LO;
        end else begin
          lo_d    = '0;
          hi_d    = $signed(n_eff - NW'(2));
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        if (lo_q < hi_q) begin
          mid_d   = IW'(msum >> 1);
          rd_idx  = IW'(msum >> 1);
          state_d = ST_TEST_MID;
        end else begin
          j_d     = IW'(lo_q);
          state_d = ST_RD_LO;
        end
      end
      ST_TEST_MID: begin
        if (coord < bp) begin
          hi_d    = $signed(NW'(mid_q) - NW'(1));
          state_d = ST_MID;
        end else begin
          rd_idx  = mid_q + IW'(1);
          state_d = ST_TEST_NEXT;
        end
      end
      ST_TEST_NEXT: begin
        if (coord >= bp) begin
          lo_d    = $signed(NW'(mid_q) + NW'(1));
          state_d = ST_MID;
        end else begin
          j_d     = mid_q;
          state_d = ST_RD_LO;
        end
      end
      // Fetch the bracket ends and form span and offset.
      ST_RD_LO: begin
        rd_idx  = j_q;
        state_d = ST_RD_HI;
      end
      ST_RD_HI: begin
        loval_d = bp;
        rd_idx  = j_q + IW'(1);
        state_d = ST_SPAN;
      end
      ST_SPAN: begin
        alu_a   = ALU_W'(bp);
        alu_b   = ALU_W'(loval_q);
        span_d  = alu_y;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        // alu holds coord - lo
        if (span_q <= 0 || alu_y <= 0) begin
          frac_d  = FRAC_ZERO;
          state_d = ST_STORE;
        end else if (alu_y >= span_q) begin
          frac_d  = FRAC_ONE;
          state_d = ST_STORE;
        end else begin
          rem_d   = alu_y;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      // Restoring division, one quotient bit per cycle.
      ST_DIV: begin
        alu_a   = rem_q <<< 1;
        alu_b   = span_q;
        div_bit = (alu_y >= 0);
        rem_d   = div_bit ? alu_y : (rem_q <<< 1);
        quo_d   = {quo_q[QUO_W-2:0], div_bit};
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          frac_d  = {1'b0, quo_q[QUO_W-2:0], div_bit};
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        if (!axis_q) begin
          t_d     = frac_q;
          ri_d    = j_q;
          axis_d  = 1'b1;
          state_d = ST_FIRST;
        end else begin
          u_d     = frac_q;
          ci_d    = j_q;
          state_d = ST_G00;
        end
      end
      // Fetch the four corners through the single grid read port.
      ST_G00: begin
        state_d = ST_G10;
      end
      ST_G10: begin
        f00_d   = grid_val;
        g_dr    = 1'b1;
        state_d = ST_G01;
      end
      ST_G01: begin
        f10_d   = grid_val;
        g_dc    = 1'b1;
        state_d = ST_G11;
      end
      ST_G11: begin
        f01_d   = grid_val;
        g_dr    = 1'b1;
        g_dc    = 1'b1;
        state_d = ST_GLAST;
      end
      ST_GLAST: begin
        f11_d   = grid_val;
        lsel_d  = 2'd0;
        state_d = ST_LSUB;
      end
      // lerp(p,q,w) = p + floor((q-p)*w / 2^16)
      ST_LSUB: begin
        alu_a   = ALU_W'(lq);
        alu_b   = ALU_W'(lp);
        diff_d  = alu_y;
        state_d = ST_LMUL;
      end
      ST_LMUL: begin
        prod_d  = ALU_W'(mul_full >>> 16);
        state_d = ST_LADD;
      end
      ST_LADD: begin
        alu_a   = ALU_W'(lp);
        alu_b   = prod_q;
        alu_sub = 1'b0;
        if (lsel_q == 2'd1) begin
          bot_d   = VAL_W'(alu_y);
          lsel_d  = 2'd2;
          state_d = ST_LSUB;
        end else if (lsel_q == 2'd0) begin
          top_d   = VAL_W'(alu_y);
          lsel_d  = 2'd1;
          state_d = ST_LSUB;
        end else begin
          top_d   = VAL_W'(alu_y);
          state_d = ST_DONE;
        end
      end
      // Hold until the result register is free.
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = top_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.kind == KIND_QUERY) |=> !req_i.ready)
    else $error("query accepted but request port stayed ready");

  a_div_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STORE) |-> (frac_q <= FRAC_ONE))
    else $error("fraction above one");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done step");

  a_bracket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_LO) |-> (NW'(j_q) <= n_eff - NW'(2)))
    else $error("bracket index outside the table");

endmodule

[tb/sv/bilinear_grid_interpolation_core_tb.sv]
// Self-checking testbench for the bilinear grid interpolation core.
// Depends on bgi_pkg, the request and response interfaces and the core itself.
`timescale 1ns / 1ps
module bilinear_grid_interpolation_core_tb;
  import bgi_pkg::*;

  localparam int  N_ROWS       = 16;
  localparam int  N_COLS       = 16;
  localparam int  QUERY_LAT    = 120;      // settling wait after the last expected result
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  RANDOM_ITEMS = 120;
  localparam int  LONG_HOLD    = 1500;
  localparam int  MAX_REPORTS  = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  bgi_req_if req_if ();
  bgi_rsp_if rsp_if ();

  bilinear_grid_interpolation_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the table and the counts.
  longint row_bp [N_ROWS];
  longint col_bp [N_COLS];
  longint grid   [N_ROWS*N_COLS];
  logic [CNT_W-1:0] row_count_q = 5'd2;
  logic [CNT_W-1:0] col_count_q = 5'd2;

  logic signed [VAL_W-1:0] pending_results [$];
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;   // receiver long stall, counted down in the ready process
  int ready_pct = 100;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int used_count(logic [CNT_W-1:0] c, int maxv);
    if (c < 2) return 2;
    if (c > maxv) return maxv;
    return int'(c);
  endfunction

  // Fixed bisection: test both ends, then narrow over 0..n-2.
  function automatic int find_bracket(longint bp [N_ROWS], int n, longint c);
    int lo, hi, mid;
    lo = 0;
    hi = n - 2;
    if (c <= bp[0]) return 0;
    if (c >= bp[n-1]) return n - 2;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (c < bp[mid]) hi = mid - 1;
      else if (c >= bp[mid+1]) lo = mid + 1;
      else return mid;
    end
    return lo;
  endfunction

  function automatic longint bracket_fraction(longint lo, longint hi, longint c);
    longint span, d;
    span = hi - lo;
    d = c - lo;
    if (span <= 0 || d <= 0) return 0;
    if (d >= span) return 65536;
    return (d * 65536) / span;
  endfunction

  // Arithmetic right shift of a signed longint floors.
  function automatic longint blend(longint p, longint q, longint w);
    return p + (((q - p) * w) >>> 16);
  endfunction

  function automatic logic signed [VAL_W-1:0] interpolate_point(longint ra, longint cb);
    int nr, nc, ri, ci;
    longint t, u, f00, f10, f01, f11, top, bot;
    nr = used_count(row_count_q, N_ROWS);
    nc = used_count(col_count_q, N_COLS);
    ri = find_bracket(row_bp, nr, ra);
    ci = find_bracket(col_bp, nc, cb);
    t = bracket_fraction(row_bp[ri], row_bp[ri+1], ra);
    u = bracket_fraction(col_bp[ci], col_bp[ci+1], cb);
    f00 = grid[ri*N_COLS + ci];
    f10 = grid[(ri+1)*N_COLS + ci];
    f01 = grid[ri*N_COLS + ci + 1];
    f11 = grid[(ri+1)*N_COLS + ci + 1];
    top = blend(f00, f10, t);
    bot = blend(f01, f11, t);
    return VAL_W'(blend(top, bot, u));
  endfunction

  // Update the shadow table or queue an expected result for one accepted request.
  task automatic apply_request(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                               logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
    case (k)
      KIND_LOAD_ROW:  if (s < N_ROWS) row_bp[s] = longint'(a);
      KIND_LOAD_COL:  if (s < N_COLS) col_bp[s] = longint'(a);
      KIND_LOAD_GRID: grid[s] = longint'(a);
      default:        pending_results.insert(pending_results.size(),
                                             interpolate_point(longint'(a), longint'(b)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                              logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.kind    <= k;
    req_if.slot    <= s;
    req_if.value_a <= a;
    req_if.value_b <= b;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
    end
    apply_request(k, s, a, b);
  endtask

  // Drop valid for an idle gap, its length given by n.
  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Random burst pattern: mostly back to back, sometimes a gap.
  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 40));
  endtask

  // Hold the sender until every expected result has come, then let loads settle.
  task automatic drain();
    idle_gap(1);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (QUERY_LAT) @(negedge clk_i);
  endtask

  task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ROW_COUNT) row_count_q = val;
    else col_count_q = val;
  endtask

  // Ordered breakpoints with random spacing; step zero now and then.
  task automatic load_axis(logic [KIND_W-1:0] k, int base, int max_step);
    int v;
    v = base;
    for (int i = 0; i < 16; i++) begin
      send_request(k, SLOT_W'(i), v, $urandom);
      maybe_gap();
      v += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, max_step);
    end
  endtask

  task automatic load_grid_random();
    for (int i = 0; i < N_ROWS*N_COLS; i++) begin
      send_request(KIND_LOAD_GRID, SLOT_W'(i), $urandom, $urandom);
      maybe_gap();
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_coord(bit col_axis);
    int n;
    longint lo, hi;
    longint bp [N_ROWS];
    if (col_axis) begin
      bp = col_bp;
      n = used_count(col_count_q, N_COLS);
    end else begin
      bp = row_bp;
      n = used_count(row_count_q, N_ROWS);
    end
    lo = bp[0];
    hi = bp[n-1];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return VAL_W'(bp[$urandom_range(0, n-1)]);
      2: return VAL_W'(lo - $urandom_range(1, 1000));
      3: return VAL_W'(hi + $urandom_range(0, 1000));
      default: begin
        if (hi > lo) return VAL_W'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
        return VAL_W'(lo);
      end
    endcase
  endfunction

  task automatic send_query();
    send_request(KIND_QUERY, SLOT_W'($urandom), pick_coord(1'b0), pick_coord(1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_load_table();
    load_axis(KIND_LOAD_ROW, -32'sd300000, 40000);
    load_axis(KIND_LOAD_COL, -32'sd100000, 30000);
    load_grid_random();
  endtask

  task automatic test_restore_axes();
    // Ordered breakpoints again on both axes; the grid stays as loaded.
    load_axis(KIND_LOAD_ROW, -32'sd250000, 50000);
    load_axis(KIND_LOAD_COL, -32'sd150000, 25000);
  endtask

  task automatic test_directed_extremes();
    // Extreme corner values and an ascending uniform table.
    for (int i = 0; i < 16; i++) begin
      send_request(KIND_LOAD_ROW, SLOT_W'(i), i * 32'sh10000, 32'sh0);
      send_request(KIND_LOAD_COL, SLOT_W'(i), i * 32'sh10000, 32'sh7fffffff);
    end
    send_request(KIND_LOAD_GRID, 8'd0,   32'sh80000000, 32'sh80000000);
    send_request(KIND_LOAD_GRID, 8'd1,   32'sh7fffffff, 32'shffffffff);
    send_request(KIND_LOAD_GRID, 8'd16,  32'sh7fffffff, 32'sh0);
    send_request(KIND_LOAD_GRID, 8'd17,  32'sh80000000, 32'sh0);
    send_request(KIND_LOAD_GRID, 8'd255, 32'sh12345678, 32'sh0);
    // Load slot beyond a breakpoint list: ignored.
    send_request(KIND_LOAD_ROW, 8'd16,  32'sh7fffffff, 32'sh0);
    send_request(KIND_LOAD_COL, 8'd255, 32'sh80000000, 32'sh0);
    // Query extremes of both coordinates, points on breakpoints and inside.
    send_request(KIND_QUERY, 8'd0,   32'sh80000000, 32'sh80000000);
    send_request(KIND_QUERY, 8'd255, 32'sh7fffffff, 32'sh7fffffff);
    send_request(KIND_QUERY, 8'd0,   32'sh00000000, 32'sh00010000);
    send_request(KIND_QUERY, 8'd0,   32'sh00008000, 32'sh00008000);
    send_request(KIND_QUERY, 8'd0,   32'sh00000001, 32'sh0000ffff);
    send_request(KIND_QUERY, 8'd0,   32'sh7fffffff, 32'sh80000000);
  endtask

  task automatic test_degenerate_breaks();
    // Zero span bracket, then unordered breakpoints.
    send_request(KIND_LOAD_ROW, 8'd1, 32'sh00000000, 32'sh0);
    send_request(KIND_QUERY, 8'd0, 32'sh00000000, 32'sh00004000);
    send_request(KIND_QUERY, 8'd0, 32'sh00000000, 32'shfffff000);
    send_request(KIND_LOAD_COL, 8'd0, 32'sh00300000, 32'sh0);
    send_request(KIND_LOAD_COL, 8'd2, 32'shfff00000, 32'sh0);
    send_request(KIND_QUERY, 8'd0, 32'sh00018000, 32'sh00020000);
    send_request(KIND_QUERY, 8'd0, 32'sh00050000, 32'sh00001000);
  endtask

  task automatic test_count_settings();
    logic [CNT_W-1:0] settings [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    foreach (settings[i]) begin
      write_count(CFG_ROW_COUNT, settings[i]);
      write_count(CFG_COL_COUNT, settings[5 - i]);
      repeat (4) begin
        send_query();
        maybe_gap();
      end
    end
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 50) begin
        write_count(CFG_ROW_COUNT, CNT_W'($urandom_range(0, 31)));
        write_count(CFG_COL_COUNT, CNT_W'($urandom_range(0, 31)));
      end
      case ($urandom_range(0, 39))
        0: send_request(KIND_LOAD_ROW, SLOT_W'($urandom_range(0, 31)), $urandom, $urandom);
        1: send_request(KIND_LOAD_COL, SLOT_W'($urandom_range(0, 31)), $urandom, $urandom);
        2, 3, 4, 5: send_request(KIND_LOAD_GRID, SLOT_W'($urandom), $urandom, $urandom);
        6: begin
          // Fresh ordered table for one axis.
          if ($urandom_range(0, 1))
            load_axis(KIND_LOAD_ROW, int'($urandom_range(0, 2000000)) - 1000000,
                      int'($urandom_range(1, 200000)));
          else
            load_axis(KIND_LOAD_COL, int'($urandom_range(0, 2000000)) - 1000000,
                      int'($urandom_range(1, 200000)));
        end
        default: send_query();
      endcase
      maybe_gap();
    end
  endtask

  task automatic test_backpressure();
    // Hold the receiver off while the sender keeps offering queries.
    hold_off = LONG_HOLD;
    repeat (6) send_query();
    // Then pause until everything has come back and go again.
    drain();
    repeat (6) send_query();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        2: ready_pct <= 30;
        default: ready_pct <= 90;
      endcase
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h at cycle %0d", rsp_if.result, cycles);
      end else begin
        if (rsp_if.result !== pending_results[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected %h actual %h at cycle %0d",
                     pending_results[0], rsp_if.result, cycles);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bilinear_grid_interpolation_core test failed");
      $finish;
    end
  end

  initial begin
    req_if.valid   = 1'b0;
    req_if.kind    = KIND_LOAD_ROW;
    req_if.slot    = '0;
    req_if.value_a = '0;
    req_if.value_b = '0;
    rsp_if.ready   = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every entry is written before the first query reads it.
    test_load_table();
    test_directed_extremes();
    test_degenerate_breaks();
    test_restore_axes();
    test_count_settings();
    test_random_mix();
    test_backpressure();

    idle_gap(1);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (QUERY_LAT) @(negedge clk_i);
    if (pending_results.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("bilinear_grid_interpolation_core test passed");
    end else begin
      $display("bilinear_grid_interpolation_core test failed");
    end
    $finish;
  end

endmodule
